>>> hw/rtl/lhbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lhbs_pkg;

  // Field widths
  localparam int IDX_W   = 10;
  localparam int CH_W    = 16;
  localparam int BYTE_W  = 8;
  localparam int MODE_W  = 2;
  localparam int LEN_W   = 11;
  localparam int CFG_A_W = 3;

  // Blob geometry, positions in Q10.17
  localparam int POS_FRAC = 17;
  localparam int POS_W    = IDX_W + POS_FRAC;
  localparam int WGT_W    = 17;
  localparam logic [CH_W-1:0] WIDTH_FLOOR = 16'd655;
  localparam logic [CH_W-1:0] HALF_MIN    = 16'd1311;

  // Falloff codes
  localparam logic [MODE_W-1:0] FALLOFF_UNIFORM = 2'd0;
  localparam logic [MODE_W-1:0] FALLOFF_SQUARED = 2'd1;
  localparam logic [MODE_W-1:0] FALLOFF_CUBED   = 2'd2;

  // Register map
  typedef enum logic [CFG_A_W-1:0] {
    CFG_HUE          = 3'd0,
    CFG_SATURATION   = 3'd1,
    CFG_RGB_LEVEL    = 3'd2,
    CFG_WHITE_LEVEL  = 3'd3,
    CFG_BLOB_CENTER  = 3'd4,
    CFG_BLOB_WIDTH   = 3'd5,
    CFG_FALLOFF_MODE = 3'd6,
    CFG_STRIP_LENGTH = 3'd7
  } cfg_reg_t;

  // Side data through the position divider
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             uni;
  } item_t;

  // Side data through the falloff divider
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             uni;
    logic             in_blob;
  } blob_t;

  // x / 65535 for x below 2^32: estimate then one correction
  function automatic logic [CH_W-1:0] div65535(input logic [31:0] x);
    logic [32:0] y;
    logic [16:0] q;
    logic [32:0] r;
    y = {1'b0, x} + {17'b0, x[31:16]};
    q = y[32:16];
    r = {1'b0, x} - (({16'b0, q} << 16) - {16'b0, q});
    if (r >= 33'd65535) begin
      q = q + 17'd1;
    end
    return q[CH_W-1:0];
  endfunction

  // x / 257 for 16-bit x: x*255>>16 then one correction
  function automatic logic [BYTE_W-1:0] div257(input logic [CH_W-1:0] x);
    logic [23:0] e;
    logic [7:0]  q;
    logic [16:0] r;
    e = ({8'b0, x} << 8) - {8'b0, x};
    q = e[23:16];
    r = {1'b0, x} - ({1'b0, q, 8'b0} + {9'b0, q});
    if (r >= 17'd257) begin
      q = q + 8'd1;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lhbs_hsv.sv
`timescale 1ns / 1ps
`default_nettype none

// Six-sector HSV to RGB bytes, free running on the configuration
module lhbs_hsv (
  input  wire logic                       clk,
  input  wire logic [lhbs_pkg::CH_W-1:0]  hue,
  input  wire logic [lhbs_pkg::CH_W-1:0]  saturation,
  input  wire logic [lhbs_pkg::CH_W-1:0]  rgb_level,
  input  wire logic [lhbs_pkg::CH_W-1:0]  white_level,
  output logic      [lhbs_pkg::BYTE_W-1:0] red,
  output logic      [lhbs_pkg::BYTE_W-1:0] green,
  output logic      [lhbs_pkg::BYTE_W-1:0] blue,
  output logic      [lhbs_pkg::BYTE_W-1:0] white
);
  import lhbs_pkg::*;

  logic [2:0]      sector1, sector2, sector3, sector4;
  logic [CH_W-1:0] frac1;
  logic [CH_W-1:0] sf2, st2;
  logic [31:0]     pm2, qm3, tm3;
  logic [CH_W-1:0] p3, p4, q4, t4;
  logic [18:0]     x6;
  logic [31:0]     sf_prod;
  logic [32:0]     st_prod;
  logic [CH_W-1:0] rf, gf, bf;

  // Stage 1: sector and fraction
  assign x6 = {3'b0, hue} * 19'd6;
  always_ff @(posedge clk) begin
    sector1 <= x6[18:16];
    frac1   <= x6[15:0];
  end

  // Stage 2: saturation products
  assign sf_prod = {16'b0, saturation} * {16'b0, frac1};
  assign st_prod = {17'b0, saturation} * (33'h10000 - {17'b0, frac1});
  always_ff @(posedge clk) begin
    sector2 <= sector1;
    sf2     <= sf_prod[31:16];
    st2     <= st_prod[31:16];
    pm2     <= {16'b0, rgb_level} * {16'b0, ~saturation};
  end

  // Stage 3: level products, p resolved
  always_ff @(posedge clk) begin
    sector3 <= sector2;
    qm3     <= {16'b0, rgb_level} * {16'b0, ~sf2};
    tm3     <= {16'b0, rgb_level} * {16'b0, ~st2};
    p3      <= div65535(pm2);
  end

  // Stage 4: q and t resolved
  always_ff @(posedge clk) begin
    sector4 <= sector3;
    p4      <= p3;
    q4      <= div65535(qm3);
    t4      <= div65535(tm3);
  end

  // Sector select
  always_comb begin
    case (sector4)
      3'd0:    begin rf = rgb_level; gf = t4;        bf = p4;        end
      3'd1:    begin rf = q4;        gf = rgb_level; bf = p4;        end
      3'd2:    begin rf = p4;        gf = rgb_level; bf = t4;        end
      3'd3:    begin rf = p4;        gf = q4;        bf = rgb_level; end
      3'd4:    begin rf = t4;        gf = p4;        bf = rgb_level; end
      default: begin rf = rgb_level; gf = p4;        bf = q4;        end
    endcase
  end

  // Stage 5: bytes
  always_ff @(posedge clk) begin
    red   <= div257(rf);
    green <= div257(gf);
    blue  <= div257(bf);
    white <= div257(white_level);
  end

endmodule

`default_nettype wire

>>> hw/rtl/lhbs_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage, side data alongside
module lhbs_div #(
  parameter int QW = 16,
  parameter int DW = 16,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  wire logic [DW-1:0] rem_in,
  input  wire logic [QW-1:0] num_in,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side_in,
  output logic               out_valid,
  output logic      [QW-1:0] quot,
  output logic      [SW-1:0] side_out
);

  logic          vld_q  [QW];
  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] num_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          vp;
    logic [DW-1:0] rp;
    logic [QW-1:0] np;
    logic [QW-1:0] qp;
    logic [SW-1:0] sp;
    logic [DW:0]   t;
    logic          ge;

    if (k == 0) begin : g_first
      assign vp = in_valid;
      assign rp = rem_in;
      assign np = num_in;
      assign qp = '0;
      assign sp = side_in;
    end else begin : g_next
      assign vp = vld_q[k-1];
      assign rp = rem_q[k-1];
      assign np = num_q[k-1];
      assign qp = quo_q[k-1];
      assign sp = side_q[k-1];
    end

    // trial subtract
    assign t  = {rp, np[QW-1]};
    assign ge = (t >= {1'b0, den});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (adv) begin
        vld_q[k] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[k]  <= ge ? DW'(t - {1'b0, den}) : DW'(t);
        num_q[k]  <= np << 1;
        quo_q[k]  <= {qp[QW-2:0], ge};
        side_q[k] <= sp;
      end
    end
  end

  assign out_valid = vld_q[QW-1];
  assign quot      = quo_q[QW-1];
  assign side_out  = side_q[QW-1];

endmodule

`default_nettype wire

>>> hw/rtl/led_pixel_hsv_blob_shader.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake           Payload
// pixel     in         in_valid/in_stall   pixel_index
// result    out        out_valid/out_stall out_index, red, green, blue, white
// config    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One pixel per cycle while out_stall does not hold a result; the path runs
// through the 27-stage position divider, the 16-stage falloff divider and
// five distance, weighting, scaling and output stages.
// Colour bytes come from a 5-stage HSV unit that follows the registers.
// Synchronous active-high reset clears valid bits and restores registers.
// The whole pixel pipeline holds while a result waits under out_stall.
module led_pixel_hsv_blob_shader #(
  parameter int MAX_PIXELS = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [lhbs_pkg::IDX_W-1:0]    pixel_index,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [lhbs_pkg::IDX_W-1:0]    out_index,
  output logic      [lhbs_pkg::BYTE_W-1:0]   red,
  output logic      [lhbs_pkg::BYTE_W-1:0]   green,
  output logic      [lhbs_pkg::BYTE_W-1:0]   blue,
  output logic      [lhbs_pkg::BYTE_W-1:0]   white,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lhbs_pkg::CFG_A_W-1:0]  cfg_index,
  input  wire logic [lhbs_pkg::CH_W-1:0]     cfg_data
);
  import lhbs_pkg::*;

  localparam logic [LEN_W-1:0] LEN_CAP =
    (MAX_PIXELS > 2047) ? 11'h7FF : LEN_W'(MAX_PIXELS);

  // Configuration registers
  logic [CH_W-1:0]   hue, saturation, rgb_level, white_level;
  logic [CH_W-1:0]   blob_center, blob_width;
  logic [MODE_W-1:0] falloff_mode;
  logic [LEN_W-1:0]  strip_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue          <= '0;
      saturation   <= '0;
      rgb_level    <= '0;
      white_level  <= '0;
      blob_center  <= 16'd32768;
      blob_width   <= 16'd32768;
      falloff_mode <= FALLOFF_UNIFORM;
      strip_length <= 11'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_HUE:          hue          <= cfg_data;
        CFG_SATURATION:   saturation   <= cfg_data;
        CFG_RGB_LEVEL:    rgb_level    <= cfg_data;
        CFG_WHITE_LEVEL:  white_level  <= cfg_data;
        CFG_BLOB_CENTER:  blob_center  <= cfg_data;
        CFG_BLOB_WIDTH:   blob_width   <= cfg_data;
        CFG_FALLOFF_MODE: falloff_mode <= cfg_data[MODE_W-1:0];
        CFG_STRIP_LENGTH: strip_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived geometry; the user must keep it stable while pixels are in flight, the block does not enforce it
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] span;
  logic [CH_W-1:0]  half;
  logic             uni;
  logic             cubed;

  assign len   = (strip_length > LEN_CAP) ? LEN_CAP : strip_length;
  assign span  = len - 11'd1;
  assign half  = (blob_width <= WIDTH_FLOOR) ? HALF_MIN : blob_width;
  assign uni   = (falloff_mode == FALLOFF_UNIFORM) || (len <= 11'd1);
  assign cubed = (falloff_mode >= FALLOFF_CUBED);

  // Colour unit
  logic [BYTE_W-1:0] hsv_r, hsv_g, hsv_b, hsv_w;

  lhbs_hsv u_hsv (
    .clk         (clk),
    .hue         (hue),
    .saturation  (saturation),
    .rgb_level   (rgb_level),
    .white_level (white_level),
    .red         (hsv_r),
    .green       (hsv_g),
    .blue        (hsv_b),
    .white       (hsv_w)
  );

  // Global advance: a stalled result holds every pixel stage
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Position divider: (index << 17) / (length - 1)
  item_t            item_in, item_p;
  logic             vp;
  logic [POS_W-1:0] pos;

  assign item_in = '{idx: pixel_index, uni: uni};

  lhbs_div #(.QW(POS_W), .DW(LEN_W), .SW($bits(item_t))) u_pos_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .rem_in    ('0),
    .num_in    ({pixel_index, {POS_FRAC{1'b0}}}),
    .den       (span),
    .side_in   (item_in),
    .out_valid (vp),
    .quot      (pos),
    .side_out  (item_p)
  );

  // Distance to centre
  logic [POS_W-1:0] ctr, dist_c;
  logic             vd;
  blob_t            blob_d;
  logic [CH_W-1:0]  dist_d;

  assign ctr    = {{(POS_W-CH_W-1){1'b0}}, blob_center, 1'b0};
  assign dist_c = (pos > ctr) ? pos - ctr : ctr - pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (adv) begin
      vd <= vp;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      blob_d <= '{idx: item_p.idx, uni: item_p.uni,
                  in_blob: (dist_c < {{(POS_W-CH_W){1'b0}}, half})};
      dist_d <= dist_c[CH_W-1:0];
    end
  end

  // Falloff divider: (d << 16) / half
  logic            vq;
  logic [CH_W-1:0] ratio;
  blob_t           blob_q;

  lhbs_div #(.QW(CH_W), .DW(CH_W), .SW($bits(blob_t))) u_fall_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (vd),
    .rem_in    (blob_d.in_blob ? dist_d : '0),
    .num_in    ('0),
    .den       (half),
    .side_in   (blob_d),
    .out_valid (vq),
    .quot      (ratio),
    .side_out  (blob_q)
  );

  // Squared weight
  logic             vf;
  blob_t            blob_f;
  logic [WGT_W-1:0] fall, fall_f, w2_f;
  logic [33:0]      sq_prod;

  assign fall    = 17'h10000 - {1'b0, ratio};
  assign sq_prod = {17'b0, fall} * {17'b0, fall};

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (adv) begin
      vf <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      blob_f <= blob_q;
      fall_f <= fall;
      w2_f   <= sq_prod[32:16];
    end
  end

  // Cubed weight and mode select
  logic             vg;
  blob_t            blob_g;
  logic [WGT_W-1:0] wgt_g;
  logic [33:0]      cu_prod;

  assign cu_prod = {17'b0, w2_f} * {17'b0, fall_f};

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (adv) begin
      vg <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      blob_g <= blob_f;
      if (!blob_f.in_blob) begin
        wgt_g <= '0;
      end else begin
        wgt_g <= cubed ? cu_prod[32:16] : w2_f;
      end
    end
  end

  // Channel scaling
  logic              vh;
  blob_t             blob_h;
  logic [BYTE_W-1:0] rs_h, gs_h, bs_h;
  logic [CH_W-1:0]   ws_h;
  logic [24:0]       r_prod, g_prod, b_prod;
  logic [32:0]       w_prod;

  assign r_prod = {17'b0, hsv_r} * {8'b0, wgt_g};
  assign g_prod = {17'b0, hsv_g} * {8'b0, wgt_g};
  assign b_prod = {17'b0, hsv_b} * {8'b0, wgt_g};
  assign w_prod = {17'b0, white_level} * {16'b0, wgt_g};

  always_ff @(posedge clk) begin
    if (rst) begin
      vh <= 1'b0;
    end else if (adv) begin
      vh <= vg;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      blob_h <= blob_g;
      rs_h   <= r_prod[23:16];
      gs_h   <= g_prod[23:16];
      bs_h   <= b_prod[23:16];
      ws_h   <= w_prod[31:16];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vh;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_index <= blob_h.idx;
      red       <= blob_h.uni ? hsv_r : rs_h;
      green     <= blob_h.uni ? hsv_g : gs_h;
      blue      <= blob_h.uni ? hsv_b : bs_h;
      white     <= blob_h.uni ? hsv_w : div257(ws_h);
    end
  end

  // Checks
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    vg |-> (wgt_g <= 17'h10000))
    else $error("blob weight above unity");

  a_outside_dark: assert property (@(posedge clk) disable iff (rst)
    (vh && !blob_h.in_blob) |-> (ws_h == '0 && rs_h == '0 && gs_h == '0 && bs_h == '0))
    else $error("pixel outside blob not dark");

  a_fall_from_ratio: assert property (@(posedge clk) disable iff (rst)
    (adv && vq && !blob_q.in_blob) |=> (w2_f == 17'h10000 || !blob_f.in_blob))
    else $error("falloff of outside pixel not at unity ratio");

endmodule

`default_nettype wire
